FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// immediate-implication and next-cycle-implication checks, disabled while the active-low reset is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SRMS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SRMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SRMS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)

`define SRMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/srms_pkg.sv
// ----------------------------------------------------------------------------
// srms_pkg
// shared widths, constants and types of the sliding rms envelope unit
// ----------------------------------------------------------------------------
package srms_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int AMOUNT_W   = 17;
    localparam int ENV_W      = 15;
    localparam int WBITS_W    = 4;
    localparam int RING_AW    = 11;
    localparam int RING_DEPTH = 2048;
    localparam int SQ_W       = 31;
    localparam int SUM_W      = 42;
    localparam int LEVEL_W    = 31;
    localparam int COEF_W     = 17;
    localparam int MUL_A_W    = 31;
    localparam int PROD_W     = 48;
    localparam int ROOT_W     = 16;
    localparam int RAD_W      = 32;
    localparam int REM_W      = 18;
    localparam int EXTRA_FRAC = 15;

    localparam logic [WBITS_W-1:0]  MAX_WBITS   = 4'd11;
    localparam logic [WBITS_W-1:0]  WBITS_RESET = 4'd11;
    localparam logic [AMOUNT_W-1:0] AMOUNT_ONE  = 17'd65536;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 31'h4000_0000;
    localparam logic [ENV_W-1:0]    ENV_MAX     = 15'h7fff;

    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
        logic [SQ_W-1:0]    data;
    } t_ring_wr;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } t_root_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_root_rsp;

endpackage

FILE: rtl/srms_ring.sv
// ----------------------------------------------------------------------------
// srms_ring
// ring of squared samples, one write and one registered read port
// ----------------------------------------------------------------------------
module srms_ring (
    input  logic                            i_clk,
    input  srms_pkg::t_ring_wr              i_wr,
    input  logic [srms_pkg::RING_AW-1:0]    i_raddr,
    output logic [srms_pkg::SQ_W-1:0]       o_rdata
);

    logic [srms_pkg::SQ_W-1:0] r_mem [srms_pkg::RING_DEPTH];
    logic [srms_pkg::SQ_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/srms_mul.sv
// ----------------------------------------------------------------------------
// srms_mul
// shared multiplier with registered product
// ----------------------------------------------------------------------------
module srms_mul (
    input  logic                            i_clk,
    input  logic [srms_pkg::MUL_A_W-1:0]    i_a,
    input  logic [srms_pkg::COEF_W-1:0]     i_b,
    output logic [srms_pkg::PROD_W-1:0]     o_p
);

    logic [srms_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= srms_pkg::PROD_W'(i_a) * srms_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

FILE: rtl/srms_isqrt.sv
// ----------------------------------------------------------------------------
// srms_isqrt
// restoring integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module srms_isqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  srms_pkg::t_root_req   i_req,
    output srms_pkg::t_root_rsp   o_rsp
);

    logic [srms_pkg::RAD_W-1:0]  r_val,  n_val;
    logic [srms_pkg::REM_W-1:0]  r_rem,  n_rem;
    logic [srms_pkg::ROOT_W-1:0] r_root, n_root;
    logic [3:0]                  r_cnt,  n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [srms_pkg::REM_W+1:0]  rem_sh;
    logic [srms_pkg::REM_W+1:0]  trial;

    always_comb begin
        rem_sh = {r_rem, r_val[srms_pkg::RAD_W-1 -: 2]};
        trial  = (srms_pkg::REM_W+2)'({r_root, 2'b01});
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_val  = i_req.radicand;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = 4'd15;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = {r_val[srms_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = srms_pkg::REM_W'(rem_sh - trial);
                n_root = {r_root[srms_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = srms_pkg::REM_W'(rem_sh);
                n_root = {r_root[srms_pkg::ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

FILE: rtl/sliding_rms_envelope_unit.sv
// ----------------------------------------------------------------------------
// sliding_rms_envelope_unit
// sliding-window rms envelope follower with one-pole rise/fall smoothing
// ----------------------------------------------------------------------------
// Each item runs through these steps before the next one is accepted: the
// sample is squared and the window sum updated, the smoothing coefficient
// is squared three times on the shared multiplier, the square root is taken
// one bit per cycle (16 iterations and the result), one multiply makes the
// smoothing step, the output register is loaded, and the block goes back
// to idle to accept the next item; most of the time goes to the square
// root. While the previous envelope item still waits in the output register
// the load cycle is held, so a stalled output adds its stall to the item. The
// ring of squares needs no clearing pass after reset or after a change of
// window_bits: a fill flag makes unwritten slots read as zero, so the block
// is ready in the first cycle after reset. Writing window_bits with a new
// value restarts the window and the smoothed level from zero.
module sliding_rms_envelope_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [srms_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [srms_pkg::AMOUNT_W-1:0]     i_rise_amount,
    input  logic [srms_pkg::AMOUNT_W-1:0]     i_fall_amount,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [srms_pkg::ENV_W-1:0]        o_envelope,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [srms_pkg::WBITS_W-1:0]      i_window_bits
);

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_COEF,
        S_ROOT,
        S_STEP,
        S_OUT
    } t_state;

    t_state                             r_state,   n_state;
    logic [1:0]                         r_cnt,     n_cnt;
    logic [srms_pkg::WBITS_W-1:0]       r_wbits,   n_wbits;
    logic [srms_pkg::RING_AW-1:0]       r_wr_idx,  n_wr_idx;
    logic                               r_filled,  n_filled;
    logic [srms_pkg::SUM_W-1:0]         r_sum,     n_sum;
    logic [srms_pkg::LEVEL_W-1:0]       r_level,   n_level;
    logic                               r_falling, n_falling;
    logic [srms_pkg::COEF_W-1:0]        r_coef,    n_coef;
    logic                               r_dir,     n_dir;
    logic                               r_out_valid, n_out_valid;
    logic [srms_pkg::ENV_W-1:0]         r_env,     n_env;

    logic [srms_pkg::WBITS_W-1:0]       eff_bits;
    logic [srms_pkg::RING_AW-1:0]       wmask;
    logic [srms_pkg::RING_AW-1:0]       next_idx;
    logic [srms_pkg::SAMPLE_W-1:0]      mag;
    logic [srms_pkg::AMOUNT_W-1:0]      amount;
    logic [srms_pkg::AMOUNT_W-1:0]      amount_clamped;
    logic [srms_pkg::SQ_W-1:0]          old_sq;
    logic [srms_pkg::PROD_W-1:0]        prod;
    logic [srms_pkg::PROD_W-1:0]        prod_rnd;
    logic [srms_pkg::COEF_W-1:0]        coef_rnd;
    logic [srms_pkg::LEVEL_W-1:0]       target;
    logic [srms_pkg::LEVEL_W-1:0]       diff;
    logic [srms_pkg::LEVEL_W-1:0]       step;
    logic [srms_pkg::LEVEL_W:0]         level_rnd;
    logic [srms_pkg::LEVEL_W-srms_pkg::EXTRA_FRAC:0] env_full;
    logic [srms_pkg::MUL_A_W-1:0]       mul_a;
    logic [srms_pkg::COEF_W-1:0]        mul_b;
    logic                               in_acc;
    logic                               cfg_acc;
    srms_pkg::t_ring_wr                 ring_wr;
    srms_pkg::t_root_req                root_req;
    srms_pkg::t_root_rsp                root_rsp;

    srms_ring u_ring (
        .i_clk   (i_clk),
        .i_wr    (ring_wr),
        .i_raddr (r_wr_idx),
        .o_rdata (old_sq)
    );

    srms_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    srms_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (root_req),
        .o_rsp   (root_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_envelope  = r_env;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        eff_bits = (r_wbits > srms_pkg::MAX_WBITS) ? srms_pkg::MAX_WBITS : r_wbits;
        wmask    = srms_pkg::RING_AW'((srms_pkg::RING_AW+1)'(1) << eff_bits) - 1'b1;
        next_idx = (r_wr_idx + 1'b1) & wmask;

        mag = i_sample[srms_pkg::SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;
        amount         = r_falling ? i_fall_amount : i_rise_amount;
        amount_clamped = (amount > srms_pkg::AMOUNT_ONE) ? srms_pkg::AMOUNT_ONE : amount;

        prod_rnd = prod + srms_pkg::PROD_W'(32768);
        coef_rnd = prod_rnd[32:16];
        step     = prod_rnd[46:16];

        target = {root_rsp.root, srms_pkg::EXTRA_FRAC'(0)};
        diff   = (target >= r_level) ? (target - r_level) : (r_level - target);

        level_rnd = {1'b0, r_level} + (srms_pkg::LEVEL_W+1)'(16384);
        env_full  = level_rnd[srms_pkg::LEVEL_W:srms_pkg::EXTRA_FRAC];

        case (r_state)
            S_IDLE: begin
                mul_a = srms_pkg::MUL_A_W'(mag);
                mul_b = srms_pkg::COEF_W'(mag);
            end
            S_SQUARE: begin
                mul_a = srms_pkg::MUL_A_W'(r_coef);
                mul_b = r_coef;
            end
            S_COEF: begin
                mul_a = srms_pkg::MUL_A_W'(coef_rnd);
                mul_b = coef_rnd;
            end
            S_ROOT: begin
                mul_a = diff;
                mul_b = r_coef;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        ring_wr.en   = (r_state == S_SQUARE);
        ring_wr.addr = r_wr_idx;
        ring_wr.data = prod[srms_pkg::SQ_W-1:0];

        root_req.start    = (r_state == S_COEF) && (r_cnt == 2'd2);
        root_req.radicand = srms_pkg::RAD_W'(r_sum >> eff_bits);

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_wbits     = r_wbits;
        n_wr_idx    = r_wr_idx;
        n_filled    = r_filled;
        n_sum       = r_sum;
        n_level     = r_level;
        n_falling   = r_falling;
        n_coef      = r_coef;
        n_dir       = r_dir;
        n_out_valid = r_out_valid;
        n_env       = r_env;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (cfg_acc && (i_window_bits != r_wbits)) begin
                    n_wbits   = i_window_bits;
                    n_wr_idx  = '0;
                    n_filled  = 1'b0;
                    n_sum     = '0;
                    n_level   = '0;
                    n_falling = 1'b0;
                end
                if (in_acc) begin
                    n_coef  = srms_pkg::AMOUNT_ONE - amount_clamped;
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                n_sum = r_sum + srms_pkg::SUM_W'(prod[srms_pkg::SQ_W-1:0])
                      - (r_filled ? srms_pkg::SUM_W'(old_sq) : srms_pkg::SUM_W'(0));
                n_wr_idx = next_idx;
                if (next_idx == '0) begin
                    n_filled = 1'b1;
                end
                n_cnt   = 2'd0;
                n_state = S_COEF;
            end
            S_COEF: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_coef  = coef_rnd;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (root_rsp.done) begin
                    n_dir   = (target >= r_level);
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_level   = r_dir ? (r_level + step) : (r_level - step);
                n_falling = !r_dir && (step != '0);
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_env = (env_full > (srms_pkg::LEVEL_W-srms_pkg::EXTRA_FRAC+1)'(
                                srms_pkg::ENV_MAX))
                          ? srms_pkg::ENV_MAX : srms_pkg::ENV_W'(env_full);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_wbits     <= srms_pkg::WBITS_RESET;
            r_wr_idx    <= '0;
            r_filled    <= 1'b0;
            r_sum       <= '0;
            r_level     <= '0;
            r_falling   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wbits     <= n_wbits;
            r_wr_idx    <= n_wr_idx;
            r_filled    <= n_filled;
            r_sum       <= n_sum;
            r_level     <= n_level;
            r_falling   <= n_falling;
            r_out_valid <= n_out_valid;
        end
        r_coef <= n_coef;
        r_dir  <= n_dir;
        r_env  <= n_env;
    end

    `SRMS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == S_SQUARE)
    `SRMS_ASSERT_IMPLY(a_root_done_waits, i_clk, i_rst_n, root_rsp.done, r_state == S_ROOT)
    `SRMS_ASSERT_IMPLY(a_level_bound, i_clk, i_rst_n, 1'b1, r_level <= srms_pkg::LEVEL_MAX)
    `SRMS_ASSERT_NEXT(a_coef_bound, i_clk, i_rst_n, root_req.start, r_coef <= srms_pkg::AMOUNT_ONE)

endmodule
